[rtl/stp_pkg.sv]
package stp_pkg;

   typedef enum logic [3:0] {
      PH_START,
      PH_SPACE,
      PH_SIGN,
      PH_ZERO,
      PH_HEXPFX,
      PH_DIGITS,
      PH_SFX,
      PH_SFX_I,
      PH_SFX_B
   } phase_type;

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [2:0] SFX_NONE = 3'd0;
   localparam logic [2:0] SFX_K    = 3'd1;
   localparam logic [2:0] SFX_M    = 3'd2;
   localparam logic [2:0] SFX_G    = 3'd3;
   localparam logic [2:0] SFX_T    = 3'd4;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_EMPTY    = 3'd1;
   localparam logic [2:0] ERR_NODIGIT  = 3'd2;
   localparam logic [2:0] ERR_DIGOVF   = 3'd3;
   localparam logic [2:0] ERR_SUFFIX   = 3'd4;
   localparam logic [2:0] ERR_TRAIL    = 3'd5;
   localparam logic [2:0] ERR_SCALEOVF = 3'd6;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LI    = 8'h69;
   localparam logic [7:0] CH_LK    = 8'h6B;
   localparam logic [7:0] CH_LM    = 8'h6D;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_LT    = 8'h74;
   localparam logic [7:0] CH_LX    = 8'h78;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  radix_code;
      logic [63:0] accumulator;
      logic        digits_overflowed;
      logic [2:0]  suffix_code;
      logic [2:0]  sticky_error;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:             PH_START,
      radix_code:        RADIX_DEC,
      accumulator:       64'd0,
      digits_overflowed: 1'b0,
      suffix_code:       SFX_NONE,
      sticky_error:      ERR_NONE
   };

endpackage

[rtl/stp_step.sv]
module stp_step (
   input  logic [7:0]          char_code,
   input  stp_pkg::state_type  cur,
   output stp_pkg::state_type  nxt,
   output logic [63:0]         res_value,
   output logic [2:0]          res_status
);
   import stp_pkg::*;

   logic [7:0]  lc;
   logic        is_dec;
   logic        is_hexa;
   logic [4:0]  raw_d;
   logic [4:0]  d;
   logic        d_ok;
   logic        is_space;
   logic [2:0]  sfx_hit;
   logic [67:0] acc_scaled;
   logic [67:0] acc_sum;
   logic        add_ovf;
   logic [2:0]  end_status;
   logic        scale_ovf;
   logic [63:0] scaled;

   always_comb begin
      lc       = (char_code >= CH_UA && char_code <= CH_UZ) ? char_code + 8'd32 : char_code;
      is_dec   = char_code >= CH_0 && char_code <= CH_9;
      is_hexa  = lc >= CH_LA && lc <= CH_LF;
      is_space = char_code == CH_SPACE || (char_code >= CH_TAB && char_code <= CH_CR);
      if (is_dec) begin
         raw_d = {1'b0, char_code[3:0]};
      end else if (is_hexa) begin
         raw_d = {1'b0, lc[3:0] + 4'd9};
      end else begin
         raw_d = 5'd16;
      end
      case (cur.radix_code)
         RADIX_OCT: d = (raw_d < 5'd8) ? raw_d : 5'd16;
         RADIX_HEX: d = raw_d;
         default:   d = (raw_d < 5'd10) ? raw_d : 5'd16;
      endcase
      d_ok = d < 5'd16;

      case (lc)
         CH_LK:   sfx_hit = SFX_K;
         CH_LM:   sfx_hit = SFX_M;
         CH_LG:   sfx_hit = SFX_G;
         CH_LT:   sfx_hit = SFX_T;
         default: sfx_hit = SFX_NONE;
      endcase

      case (cur.radix_code)
         RADIX_OCT: acc_scaled = {1'b0, cur.accumulator, 3'b000};
         RADIX_HEX: acc_scaled = {cur.accumulator, 4'b0000};
         default:   acc_scaled = {1'b0, cur.accumulator, 3'b000} +
                                 {3'b000, cur.accumulator, 1'b0};
      endcase
      acc_sum = acc_scaled + {64'd0, d[3:0]};
      add_ovf = cur.digits_overflowed || (acc_sum[67:64] != 4'd0);

      case (cur.suffix_code)
         SFX_NONE: begin
            scale_ovf = 1'b0;
            scaled    = cur.accumulator;
         end
         SFX_K: begin
            scale_ovf = cur.accumulator[63:54] != 10'd0;
            scaled    = {cur.accumulator[53:0], 10'd0};
         end
         SFX_M: begin
            scale_ovf = cur.accumulator[63:44] != 20'd0;
            scaled    = {cur.accumulator[43:0], 20'd0};
         end
         SFX_G: begin
            scale_ovf = cur.accumulator[63:34] != 30'd0;
            scaled    = {cur.accumulator[33:0], 30'd0};
         end
         default: begin
            scale_ovf = cur.accumulator[63:24] != 40'd0;
            scaled    = {cur.accumulator[23:0], 40'd0};
         end
      endcase

      if (cur.sticky_error != ERR_NONE) begin
         end_status = cur.sticky_error;
      end else if (cur.phase == PH_START) begin
         end_status = ERR_EMPTY;
      end else if (cur.phase == PH_SPACE || cur.phase == PH_SIGN) begin
         end_status = ERR_NODIGIT;
      end else if (cur.phase == PH_HEXPFX) begin
         end_status = ERR_SUFFIX;
      end else if (cur.phase == PH_DIGITS && cur.digits_overflowed) begin
         end_status = ERR_DIGOVF;
      end else if (scale_ovf) begin
         end_status = ERR_SCALEOVF;
      end else begin
         end_status = ERR_NONE;
      end
      res_status = end_status;
      res_value  = (end_status == ERR_NONE) ? scaled : 64'd0;

      nxt = cur;
      if (char_code == CH_NUL) begin
         nxt = STATE_RESET;
      end else if (cur.sticky_error == ERR_NONE) begin
         case (cur.phase)
            PH_START, PH_SPACE: begin
               if (is_space) begin
                  nxt.phase = PH_SPACE;
               end else if (char_code == CH_MINUS) begin
                  nxt.sticky_error = ERR_EMPTY;
               end else if (char_code == CH_PLUS) begin
                  nxt.phase = PH_SIGN;
               end else if (char_code == CH_0) begin
                  nxt.radix_code = RADIX_OCT;
                  nxt.phase      = PH_ZERO;
               end else if (char_code >= CH_1 && char_code <= CH_9) begin
                  nxt.radix_code  = RADIX_DEC;
                  nxt.accumulator = {60'd0, char_code[3:0]};
                  nxt.phase       = PH_DIGITS;
               end else begin
                  nxt.sticky_error = ERR_NODIGIT;
               end
            end
            PH_SIGN: begin
               if (char_code == CH_0) begin
                  nxt.radix_code = RADIX_OCT;
                  nxt.phase      = PH_ZERO;
               end else if (char_code >= CH_1 && char_code <= CH_9) begin
                  nxt.radix_code  = RADIX_DEC;
                  nxt.accumulator = {60'd0, char_code[3:0]};
                  nxt.phase       = PH_DIGITS;
               end else begin
                  nxt.sticky_error = ERR_NODIGIT;
               end
            end
            PH_ZERO: begin
               if (lc == CH_LX) begin
                  nxt.radix_code = RADIX_HEX;
                  nxt.phase      = PH_HEXPFX;
               end else if (char_code >= CH_0 && char_code <= CH_7) begin
                  nxt.accumulator = {60'd0, char_code[3:0]};
                  nxt.phase       = PH_DIGITS;
               end else if (sfx_hit != SFX_NONE) begin
                  nxt.suffix_code = sfx_hit;
                  nxt.phase       = PH_SFX;
               end else begin
                  nxt.sticky_error = ERR_SUFFIX;
               end
            end
            PH_HEXPFX: begin
               if (d_ok) begin
                  nxt.accumulator = {60'd0, d[3:0]};
                  nxt.phase       = PH_DIGITS;
               end else begin
                  nxt.sticky_error = ERR_SUFFIX;
               end
            end
            PH_DIGITS: begin
               if (d_ok) begin
                  nxt.digits_overflowed = add_ovf;
                  nxt.accumulator       = add_ovf ? {64{1'b1}} : acc_sum[63:0];
               end else if (cur.digits_overflowed) begin
                  nxt.sticky_error = ERR_DIGOVF;
               end else if (sfx_hit != SFX_NONE) begin
                  nxt.suffix_code = sfx_hit;
                  nxt.phase       = PH_SFX;
               end else begin
                  nxt.sticky_error = ERR_SUFFIX;
               end
            end
            PH_SFX: begin
               if (lc == CH_LI) begin
                  nxt.phase = PH_SFX_I;
               end else if (lc == CH_LB) begin
                  nxt.phase = PH_SFX_B;
               end else begin
                  nxt.sticky_error = ERR_TRAIL;
               end
            end
            PH_SFX_I: begin
               if (lc == CH_LB) begin
                  nxt.phase = PH_SFX_B;
               end else begin
                  nxt.sticky_error = ERR_TRAIL;
               end
            end
            default: begin
               nxt.sticky_error = ERR_TRAIL;
            end
         endcase
      end
   end

endmodule

[rtl/size_text_parser.sv]
// Parses a size written as text, one byte per transfer, and returns one result
// transfer per zero byte. A byte can be accepted in every cycle; a result is
// written to the output register when its terminating zero byte moves from the
// input register through the character step logic. Input is held off only when
// a zero byte waits in the input register while an earlier result is still
// stalled in the output register.
module size_text_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_size_value,
   output logic [2:0]  rsp_status
);
   import stp_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   state_type   state_ff;
   state_type   state_in;
   logic        out_valid_ff;
   logic [63:0] out_value_ff;
   logic [2:0]  out_status_ff;
   logic [63:0] step_value;
   logic [2:0]  step_status;
   logic        is_end;
   logic        advance;

   stp_step u_step (
      .char_code  (in_char_ff),
      .cur        (state_ff),
      .nxt        (state_in),
      .res_value  (step_value),
      .res_status (step_status)
   );

   assign is_end    = in_char_ff == CH_NUL;
   assign advance   = in_valid_ff && !(is_end && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && is_end) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
      end
      if (advance && is_end) begin
         out_value_ff  <= step_value;
         out_status_ff <= step_status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_size_value = out_value_ff;
   assign rsp_status     = out_status_ff;

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ERR_SCALEOVF)
      else $error("result status out of range");

   a_value_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ERR_NONE) |-> rsp_size_value == 64'd0)
      else $error("nonzero size with error status");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && is_end) |=> (state_ff == STATE_RESET && out_valid_ff))
      else $error("state not cleared after end of string");

   a_stall_only_on_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && is_end && out_valid_ff))
      else $error("input held off without a pending result");

endmodule
